// ===== src/plil_pkg.sv =====
package plil_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_O_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_LOOP,
        S_INS_MOVE,
        S_DEL_LOOP,
        S_DEL_MOVE,
        S_RD_WAIT,
        S_FINISH
    } state_t;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_INS_START,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_DEL_START,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_DEL_END,
        OP_RD_ADDR,
        OP_RD_TAKE,
        OP_BAD,
        OP_FULL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic start;
        logic bad_ins;
        logic bad_pos;
        logic full;
        logic ins_more;
        logic del_more;
    } dp_stat_t;

endpackage

// ===== src/plil_ram.sv =====
module plil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/plil_ctrl.sv =====
module plil_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  plil_pkg::dp_stat_t stat,
    output plil_pkg::dp_cmd_t  cmd
);

    plil_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plil_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            plil_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = plil_pkg::S_DECIDE;
                end
            end
            plil_pkg::S_DECIDE:
            begin
                priority if (stat.req == plil_pkg::REQ_INSERT && !stat.bad_ins && !stat.full)
                begin
                    state_next = plil_pkg::S_INS_LOOP;
                end
                else if (stat.req == plil_pkg::REQ_DELETE && !stat.bad_pos)
                begin
                    state_next = plil_pkg::S_DEL_LOOP;
                end
                else if (stat.req == plil_pkg::REQ_READ && !stat.bad_pos)
                begin
                    state_next = plil_pkg::S_RD_WAIT;
                end
                else
                begin
                    state_next = plil_pkg::S_FINISH;
                end
            end
            plil_pkg::S_INS_LOOP:
            begin
                state_next = stat.ins_more ? plil_pkg::S_INS_MOVE : plil_pkg::S_FINISH;
            end
            plil_pkg::S_INS_MOVE:
            begin
                state_next = plil_pkg::S_INS_LOOP;
            end
            plil_pkg::S_DEL_LOOP:
            begin
                state_next = stat.del_more ? plil_pkg::S_DEL_MOVE : plil_pkg::S_FINISH;
            end
            plil_pkg::S_DEL_MOVE:
            begin
                state_next = plil_pkg::S_DEL_LOOP;
            end
            plil_pkg::S_RD_WAIT:
            begin
                state_next = plil_pkg::S_FINISH;
            end
            plil_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = plil_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plil_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op       = plil_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            plil_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = plil_pkg::OP_CAPTURE;
                end
            end
            plil_pkg::S_DECIDE:
            begin
                unique case (stat.req)
                    plil_pkg::REQ_LOAD:
                    begin
                        cmd.op = (stat.start || !stat.full) ? plil_pkg::OP_LOAD
                                                            : plil_pkg::OP_FULL;
                    end
                    plil_pkg::REQ_INSERT:
                    begin
                        priority if (stat.bad_ins)
                        begin
                            cmd.op = plil_pkg::OP_BAD;
                        end
                        else if (stat.full)
                        begin
                            cmd.op = plil_pkg::OP_FULL;
                        end
                        else
                        begin
                            cmd.op = plil_pkg::OP_INS_START;
                        end
                    end
                    plil_pkg::REQ_DELETE:
                    begin
                        cmd.op = stat.bad_pos ? plil_pkg::OP_BAD : plil_pkg::OP_DEL_START;
                    end
                    plil_pkg::REQ_READ:
                    begin
                        cmd.op = stat.bad_pos ? plil_pkg::OP_BAD : plil_pkg::OP_RD_ADDR;
                    end
                    default:
                    begin
                        cmd.op = plil_pkg::OP_NONE;
                    end
                endcase
            end
            plil_pkg::S_INS_LOOP:
            begin
                cmd.op = stat.ins_more ? plil_pkg::OP_INS_RD : plil_pkg::OP_INS_PUT;
            end
            plil_pkg::S_INS_MOVE:
            begin
                cmd.op = plil_pkg::OP_INS_WR;
            end
            plil_pkg::S_DEL_LOOP:
            begin
                cmd.op = stat.del_more ? plil_pkg::OP_DEL_RD : plil_pkg::OP_DEL_END;
            end
            plil_pkg::S_DEL_MOVE:
            begin
                cmd.op = plil_pkg::OP_DEL_WR;
            end
            plil_pkg::S_RD_WAIT:
            begin
                cmd.op = plil_pkg::OP_RD_TAKE;
            end
            plil_pkg::S_FINISH:
            begin
                cmd.out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd.op = plil_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == plil_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/plil_dp.sv =====
module plil_dp #(
    parameter int CAPACITY = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  plil_pkg::dp_cmd_t                     cmd,
    output plil_pkg::dp_stat_t                    stat,
    input  logic [plil_pkg::REQ_W-1:0]            req_type,
    input  logic [plil_pkg::POS_W-1:0]            position,
    input  logic signed [plil_pkg::DATA_W-1:0]    value,
    input  logic                                  start_new,
    output logic [plil_pkg::STATUS_W-1:0]         status,
    output logic signed [plil_pkg::DATA_W-1:0]    read_value,
    output logic [plil_pkg::COUNT_O_W-1:0]        element_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > plil_pkg::POS_W) ? CW : plil_pkg::POS_W) + 1;

    // captured request
    plil_pkg::req_t              req_reg;
    logic [plil_pkg::POS_W-1:0]  pos_reg;
    logic [plil_pkg::DATA_W-1:0] val_reg;
    logic                        start_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;

    plil_pkg::status_t           res_status_reg, res_status_next;
    logic [plil_pkg::DATA_W-1:0] res_value_reg, res_value_next;

    logic [plil_pkg::STATUS_W-1:0]  out_status_reg;
    logic [plil_pkg::DATA_W-1:0]    out_value_reg;
    logic [plil_pkg::COUNT_O_W-1:0] out_count_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [plil_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

    logic [XW-1:0] pos_x, cnt_x, idx_x;
    logic [AW-1:0] pos_m1;

    assign pos_x  = XW'(pos_reg);
    assign cnt_x  = XW'(count_reg);
    assign idx_x  = XW'(idx_reg);
    assign pos_m1 = AW'(pos_x - XW'(1));

    assign stat.req      = req_reg;
    assign stat.start    = start_reg;
    assign stat.bad_ins  = (pos_reg == '0) || (pos_x > cnt_x + XW'(1));
    assign stat.bad_pos  = (pos_reg == '0) || (pos_x > cnt_x);
    assign stat.full     = (count_reg == CW'(CAPACITY));
    assign stat.ins_more = idx_x > (pos_x - XW'(1));
    assign stat.del_more = (idx_x + XW'(1)) < cnt_x;

    plil_ram #(
        .WIDTH (plil_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        unique case (cmd.op)
            plil_pkg::OP_CAPTURE:
            begin
                res_status_next = plil_pkg::ST_DONE;
                res_value_next  = '0;
            end
            plil_pkg::OP_LOAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = start_reg ? '0 : AW'(count_reg);
                ram_wdata  = val_reg;
                count_next = start_reg ? CW'(1) : count_reg + CW'(1);
            end
            plil_pkg::OP_INS_START:
            begin
                idx_next = AW'(count_reg);
            end
            plil_pkg::OP_INS_RD:
            begin
                ram_raddr = idx_reg - AW'(1);
            end
            plil_pkg::OP_INS_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg - AW'(1);
            end
            plil_pkg::OP_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_m1;
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end
            plil_pkg::OP_DEL_START:
            begin
                idx_next = pos_m1;
            end
            plil_pkg::OP_DEL_RD:
            begin
                ram_raddr = idx_reg + AW'(1);
            end
            plil_pkg::OP_DEL_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + AW'(1);
            end
            plil_pkg::OP_DEL_END:
            begin
                count_next = count_reg - CW'(1);
            end
            plil_pkg::OP_RD_ADDR:
            begin
                ram_raddr = pos_m1;
            end
            plil_pkg::OP_RD_TAKE:
            begin
                res_value_next = ram_rdata;
            end
            plil_pkg::OP_BAD:
            begin
                res_status_next = plil_pkg::ST_BAD_POS;
            end
            plil_pkg::OP_FULL:
            begin
                res_status_next = plil_pkg::ST_FULL;
            end
            plil_pkg::OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == plil_pkg::OP_CAPTURE)
        begin
            req_reg   <= plil_pkg::req_t'(req_type);
            pos_reg   <= position;
            val_reg   <= value;
            start_reg <= start_new;
        end
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= plil_pkg::COUNT_O_W'(count_reg);
        end
    end

    assign status        = out_status_reg;
    assign read_value    = out_value_reg;
    assign element_count = out_count_reg;

endmodule

// ===== src/positional_insert_delete_list.sv =====
// Positional insert/delete list of signed 32-bit values, up to CAPACITY entries.
//
// Input channel (in_valid/in_ready): one transaction is one request -- load
// (append, start_new empties the list first), insert at a 1-based position,
// delete at a position, or read at a position. Output channel
// (out_valid/out_ready): exactly one result transaction per request with
// status, read_value (zero unless a good read) and element_count.
//
// Entries live in a single-port-write, registered-read RAM; inserts and deletes
// move one entry at a time (RAM read, then write back one slot over).
// One request is in flight at a time; the next is accepted in the cycle after
// its result enters the output register.
//
// Reset clears the count (empty list) and the output valid; RAM contents are
// not cleared and need no clearing pass. If the receiver stalls, the result
// holds in the output register; the next request is still accepted and
// worked on, and waits at its final step until the register frees up.
module positional_insert_delete_list #(
    parameter int CAPACITY = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [plil_pkg::REQ_W-1:0]         req_type,
    input  logic [plil_pkg::POS_W-1:0]         position,
    input  logic signed [plil_pkg::DATA_W-1:0] value,
    input  logic                               start_new,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [plil_pkg::STATUS_W-1:0]      status,
    output logic signed [plil_pkg::DATA_W-1:0] read_value,
    output logic [plil_pkg::COUNT_O_W-1:0]     element_count
);

    plil_pkg::dp_cmd_t  cmd;
    plil_pkg::dp_stat_t stat;

    // sequencer: request decode, shift loops, output handoff
    plil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // list storage, count, shift index and result registers
    plil_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .position      (position),
        .value         (value),
        .start_new     (start_new),
        .status        (status),
        .read_value    (read_value),
        .element_count (element_count)
    );

    // a request in flight blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request accepted while busy");

    // non-read or rejected results carry a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != plil_pkg::ST_DONE) |-> (read_value == '0))
        else $error("nonzero read_value on failed request");

    // never overwrite an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // final insert write only happens with room in the list
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == plil_pkg::OP_INS_PUT) |-> !stat.full)
        else $error("insert into full list");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    // Depth of the list under test; the instance gets the same value.
    localparam int CAPACITY    = 128;
    localparam int ITEMS_TOTAL = 1100;
    // Worst insert moves 127 entries, each with one RAM read and one write.
    localparam int DRAIN_WAIT  = 300;
    localparam int CYCLE_LIMIT = 2_000_000;
    // Long receiver hold-off: starts once this many requests went in.
    localparam int HOLDOFF_AT  = 150;
    localparam int HOLDOFF_LEN = 250;
    // The sender stops once, after this many requests were queued,
    // until every reply is back.
    localparam int DRAIN_AT    = 600;

    // One request as it goes out on the input channel.
    typedef struct packed {
        plil_pkg::req_t                     rq;
        logic [plil_pkg::POS_W-1:0]         pos;
        logic signed [plil_pkg::DATA_W-1:0] val;
        logic                               st;
    } list_req_t;

    // One reply as the output channel should carry it.
    typedef struct packed {
        plil_pkg::status_t                  status;
        logic signed [plil_pkg::DATA_W-1:0] read_value;
        logic [plil_pkg::COUNT_O_W-1:0]     element_count;
    } list_reply_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    logic [plil_pkg::REQ_W-1:0]         req_type  = '0;
    logic [plil_pkg::POS_W-1:0]         position  = '0;
    logic signed [plil_pkg::DATA_W-1:0] value     = '0;
    logic                               start_new = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [plil_pkg::STATUS_W-1:0]      status;
    logic signed [plil_pkg::DATA_W-1:0] read_value;
    logic [plil_pkg::COUNT_O_W-1:0]     element_count;

    positional_insert_delete_list #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .position      (position),
        .value         (value),
        .start_new     (start_new),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .read_value    (read_value),
        .element_count (element_count)
    );

    // ------------------------------------------------------------------
    // Shadow of the list and the predictor.
    // The shadow is advanced as requests are queued; since the block serves
    // requests strictly in order, replies_due lines up with the replies.
    // ------------------------------------------------------------------
    logic signed [plil_pkg::DATA_W-1:0] shadow_list[$];
    list_reply_t                        replies_due[$];
    list_req_t                          req_queue[$];

    int n_queued   = 0;
    int n_accepted = 0;   // input transactions taken by the block
    int n_got      = 0;   // output transactions that matched an expectation
    int err_cnt    = 0;
    int cycle_cnt  = 0;
    bit in_fire    = 1'b0;

    // Apply one request to the shadow list and return the reply it causes.
    function automatic list_reply_t list_reply_for(list_req_t it);
        list_reply_t r;
        int          n;
        int          p;
        r.status     = plil_pkg::ST_DONE;
        r.read_value = '0;
        n = shadow_list.size();
        p = int'(it.pos);
        case (it.rq)
            plil_pkg::REQ_LOAD:
            begin
                // start flag empties the list first, so a restart never fails
                if (it.st)
                    shadow_list.delete();
                if (shadow_list.size() >= CAPACITY)
                    r.status = plil_pkg::ST_FULL;
                else
                    shadow_list.push_back(it.val);
            end
            plil_pkg::REQ_INSERT:
            begin
                // position is checked before fullness
                if (p < 1 || p > n + 1)
                    r.status = plil_pkg::ST_BAD_POS;
                else if (n >= CAPACITY)
                    r.status = plil_pkg::ST_FULL;
                else
                    shadow_list.insert(p - 1, it.val);
            end
            plil_pkg::REQ_DELETE:
            begin
                if (p < 1 || p > n)
                    r.status = plil_pkg::ST_BAD_POS;
                else
                    shadow_list.delete(p - 1);
            end
            default:
            begin
                if (p < 1 || p > n)
                    r.status = plil_pkg::ST_BAD_POS;
                else
                    r.read_value = shadow_list[p - 1];
            end
        endcase
        r.element_count = plil_pkg::COUNT_O_W'(shadow_list.size());
        return r;
    endfunction

    task automatic send(plil_pkg::req_t rq, int pos,
                        logic signed [plil_pkg::DATA_W-1:0] v, bit st);
        list_req_t it;
        it.rq  = rq;
        it.pos = plil_pkg::POS_W'(pos);
        it.val = v;
        it.st  = st;
        req_queue.push_back(it);
        replies_due.push_back(list_reply_for(it));
        n_queued++;
    endtask

    // Mostly random words, with the corners of the signed range mixed in.
    function automatic logic signed [plil_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // Out-of-range position: zero or anything above the legal top.
    function automatic int bad_pos(int top);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(top + 1, 255);
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mixed traffic on a list kept moderate in size so shifts stay short.
    task automatic run_mixed(int len);
        int             n;
        int             r;
        int             ins_w;
        int             del_w;
        int             pos;
        bit             bad;
        bit             st;
        plil_pkg::req_t rq;
        repeat (len)
        begin
            n     = shadow_list.size();
            ins_w = (n > 48) ? 15 : 35;
            del_w = (n > 48) ? 40 : ((n < 4) ? 8 : 25);
            r     = $urandom_range(0, 99);
            bad   = ($urandom_range(0, 9) == 0);
            if (r < 15)
                rq = plil_pkg::REQ_LOAD;
            else if (r < 15 + ins_w)
                rq = plil_pkg::REQ_INSERT;
            else if (r < 15 + ins_w + del_w)
                rq = plil_pkg::REQ_DELETE;
            else
                rq = plil_pkg::REQ_READ;
            case (rq)
                plil_pkg::REQ_LOAD:   pos = $urandom_range(0, 255);
                plil_pkg::REQ_INSERT: pos = bad ? bad_pos(n + 1) : $urandom_range(1, n + 1);
                default:    pos = (bad || n == 0) ? bad_pos(n) : $urandom_range(1, n);
            endcase
            if (rq == plil_pkg::REQ_LOAD)
                st = ($urandom_range(0, 9) == 0);
            else
                st = 1'($urandom_range(0, 1));
            send(rq, pos, pick_value(), st);
        end
    endtask

    // Fill the list to capacity, then poke at the full list.
    task automatic run_fill();
        int n;
        if ($urandom_range(0, 1))
            send(plil_pkg::REQ_LOAD, $urandom_range(0, 255), pick_value(), 1'b1);
        while (shadow_list.size() < CAPACITY)
        begin
            n = shadow_list.size();
            if (n > 0 && $urandom_range(0, 9) == 0)
                send(plil_pkg::REQ_INSERT, $urandom_range(1, n + 1), pick_value(),
                     1'($urandom_range(0, 1)));
            else
                send(plil_pkg::REQ_LOAD, $urandom_range(0, 255), pick_value(), 1'b0);
        end
        // full
        send(plil_pkg::REQ_LOAD, $urandom_range(0, 255), pick_value(), 1'b0);
        // full, at end
        send(plil_pkg::REQ_INSERT, CAPACITY + 1, pick_value(), 1'b0);
        // full
        send(plil_pkg::REQ_INSERT, $urandom_range(1, CAPACITY), pick_value(), 1'b1);
        // bad beats full
        send(plil_pkg::REQ_INSERT, bad_pos(CAPACITY + 1), pick_value(), 1'b0);
        send(plil_pkg::REQ_READ, CAPACITY, 0, 1'b0);
        send(plil_pkg::REQ_READ, $urandom_range(1, CAPACITY), 0, 1'b1);
        send(plil_pkg::REQ_READ, CAPACITY + 1, 0, 1'b0);
        send(plil_pkg::REQ_DELETE, $urandom_range(1, CAPACITY), 0, 1'b0);
        // full again
        send(plil_pkg::REQ_INSERT, $urandom_range(1, CAPACITY), pick_value(), 1'b0);
        send(plil_pkg::REQ_DELETE, CAPACITY, 0, 1'b0);
        // shrink back: restart with a fresh first entry or delete a batch
        if ($urandom_range(0, 1))
            send(plil_pkg::REQ_LOAD, $urandom_range(0, 255), pick_value(), 1'b1);
        else
            repeat (100)
                send(plil_pkg::REQ_DELETE, $urandom_range(1, shadow_list.size()), 0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Input side: note each accepted transaction at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire    <= 1'b0;
            n_accepted <= 0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                n_accepted <= n_accepted + 1;
        end
    end

    // Driver: works on the falling edge. A pending request holds valid and
    // payload until the edge that takes it; gaps are inserted after it.
    int gap_left     = 0;
    int stretch_left = 0;
    bit no_idle      = 1'b0;   // stretches where neither side idles

    always @(negedge clk)
    begin : drive
        list_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_queue.size() > 0)
            begin
                nxt = req_queue.pop_front();
                if (stretch_left == 0)
                begin
                    no_idle      = ($urandom_range(0, 4) == 0);
                    stretch_left = $urandom_range(20, 80);
                end
                stretch_left--;
                in_valid  <= 1'b1;
                req_type  <= nxt.rq;
                position  <= nxt.pos;
                value     <= nxt.val;
                start_new <= nxt.st;
                gap_left = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off while the sender
    // keeps offering so the block backs up and drops in_ready.
    // ------------------------------------------------------------------
    int stall_left   = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else if (!holdoff_done && n_accepted >= HOLDOFF_AT)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            out_ready <= 1'b0;
        end
        else if (no_idle)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // Monitor: each output transaction is checked against the oldest
    // expectation of a request the block has already taken.
    task automatic check_field(string fld, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("reply %0d: %s expected %0d (0x%08h), got %0d (0x%08h)",
                         n_got, fld, $signed(want), want, $signed(got), got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        list_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (n_got >= n_accepted || replies_due.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("reply with nothing outstanding: status %0d value %0d count %0d",
                             status, read_value, element_count);
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("read_value", want.read_value, read_value);
                check_field("element_count", 32'(want.element_count), 32'(element_count));
                n_got <= n_got + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------
    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic wait_all_replies();
        while (!(req_queue.size() == 0 && !in_valid && n_got == n_accepted))
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int  seg;
        bit  drained;
        seg     = 0;
        drained = 1'b0;

        // Directed: empty list, bad positions on insert, delete and read, insert at
        // both ends, reads of every entry, deletes at both ends, restarts.
        send(plil_pkg::REQ_READ,   1,   0, 1'b0);             // read on empty
        send(plil_pkg::REQ_DELETE, 0,   0, 1'b0);             // delete on empty
        send(plil_pkg::REQ_INSERT, 2,   pick_value(), 1'b0);  // beyond count+1
        send(plil_pkg::REQ_INSERT, 0,   pick_value(), 1'b1);  // position zero
        send(plil_pkg::REQ_INSERT, 1,   32'sh7fff_ffff, 1'b1); // start flag ignored
        send(plil_pkg::REQ_LOAD,   255, 32'sh8000_0000, 1'b0);
        send(plil_pkg::REQ_INSERT, 3,   -32'sd1, 1'b0);       // at count+1
        send(plil_pkg::REQ_INSERT, 1,   32'sd0, 1'b0);        // at the head
        send(plil_pkg::REQ_INSERT, 255, pick_value(), 1'b0);
        send(plil_pkg::REQ_READ,   1,   0, 1'b0);
        send(plil_pkg::REQ_READ,   2,   0, 1'b1);
        send(plil_pkg::REQ_READ,   3,   0, 1'b0);
        send(plil_pkg::REQ_READ,   4,   0, 1'b0);
        send(plil_pkg::REQ_READ,   5,   0, 1'b0);             // count+1
        send(plil_pkg::REQ_READ,   0,   0, 1'b0);
        send(plil_pkg::REQ_DELETE, 5,   0, 1'b0);             // count+1
        send(plil_pkg::REQ_DELETE, 4,   0, 1'b0);             // last entry
        send(plil_pkg::REQ_DELETE, 1,   0, 1'b1);             // first entry
        send(plil_pkg::REQ_LOAD,   0,   32'sh5555_5555, 1'b1); // restart
        send(plil_pkg::REQ_LOAD,   129, 32'shaaaa_aaaa, 1'b0);
        send(plil_pkg::REQ_READ,   2,   0, 1'b0);
        send(plil_pkg::REQ_READ,   129, 0, 1'b0);
        send(plil_pkg::REQ_DELETE, 1,   0, 1'b0);
        send(plil_pkg::REQ_DELETE, 1,   0, 1'b0);             // now empty
        send(plil_pkg::REQ_READ,   1,   0, 1'b0);

        // Random: mixed traffic, with fills to capacity sprinkled in.
        while (n_queued < ITEMS_TOTAL)
        begin
            if (seg == 1 || seg == 9 || $urandom_range(0, 11) == 0)
                run_fill();
            else
                run_mixed($urandom_range(20, 60));
            seg++;
            if (!drained && n_queued >= DRAIN_AT)
            begin
                // sender goes quiet until everything is back
                wait_all_replies();
                drained = 1'b1;
            end
        end

        wait_all_replies();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0 && replies_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
